[design/jtag_tap_trace_checker_defines.svh]
// ----------------------------------------------------------------------------
// JTAG TAP trace checker assertion macros
// Shared assertion wrappers; NO_ASSERTIONS removes every check.
// ----------------------------------------------------------------------------
`ifndef JTAG_TAP_TRACE_CHECKER_DEFINES_SVH
`define JTAG_TAP_TRACE_CHECKER_DEFINES_SVH

`ifndef NO_ASSERTIONS

// Same-cycle implication, disabled while reset is asserted.
`define JTTC_ASSERT_IMPLIES(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("jttc assertion failed");

// Next-cycle implication, disabled while reset is asserted.
`define JTTC_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("jttc assertion failed");

`else

`define JTTC_ASSERT_IMPLIES(label, clk, rst_n, ante, cons)
`define JTTC_ASSERT_NEXT(label, clk, rst_n, ante, cons)

`endif

`endif

[design/jttc_pkg.sv]
// ----------------------------------------------------------------------------
// JTAG TAP trace checker package
// Field widths, record kinds, TAP state codes and the legal successor table.
// ----------------------------------------------------------------------------
package jttc_pkg;

    // Field widths.
    localparam int WORD_W     = 32;
    localparam int KIND_W     = 3;
    localparam int FROM_W     = 5;
    localparam int TAP_W      = 4;
    localparam int TICK_W     = 27;
    localparam int TIME_W     = 31;
    localparam int IR_LEN_W   = 8;
    localparam int BYPASS_W   = 6;
    localparam int PADDR_W    = 3;
    localparam int PDATA_W    = 32;

    // Configuration register index (word address bit 2).
    localparam logic REG_IR_CHAIN_LENGTH = 1'b0;
    localparam logic [IR_LEN_W-1:0] IR_LEN_RESET = 8'd22;

    // Record kinds.
    localparam logic [KIND_W-1:0] KIND_SEQ_ERR    = 3'd0;
    localparam logic [KIND_W-1:0] KIND_ILLEGAL    = 3'd1;
    localparam logic [KIND_W-1:0] KIND_RESET      = 3'd2;
    localparam logic [KIND_W-1:0] KIND_IDLE       = 3'd3;
    localparam logic [KIND_W-1:0] KIND_PAUSE      = 3'd4;
    localparam logic [KIND_W-1:0] KIND_IR_MATCHED = 3'd5;
    localparam logic [KIND_W-1:0] KIND_IR_OTHER   = 3'd6;
    localparam logic [KIND_W-1:0] KIND_DR         = 3'd7;

    // TAP state codes of interest.
    localparam logic [TAP_W-1:0]  ST_RESET    = 4'd0;
    localparam logic [TAP_W-1:0]  ST_DR_EXIT1 = 4'd4;
    localparam logic [TAP_W-1:0]  ST_DR_PAUSE = 4'd5;
    localparam logic [TAP_W-1:0]  ST_IDLE     = 4'd8;
    localparam logic [TAP_W-1:0]  ST_IR_EXIT1 = 4'd12;
    localparam logic [TAP_W-1:0]  ST_IR_PAUSE = 4'd13;
    localparam logic [FROM_W-1:0] ST_NONE     = 5'd16;

    localparam logic [BYPASS_W-1:0] BYPASS_ALL = 6'h3F;

    // Bit n of entry s is set when state n may follow state s.
    localparam logic [15:0] NEXT_OK [16] = '{
        16'h0100, 16'h0204, 16'h0018, 16'h0010,
        16'h00A0, 16'h0040, 16'h0088, 16'h0102,
        16'h0002, 16'h0401, 16'h1800, 16'h1000,
        16'hA000, 16'h4000, 16'h8800, 16'h0102
    };

    // One result item.
    typedef struct packed {
        logic [KIND_W-1:0] record_kind;
        logic [FROM_W-1:0] from_state;
        logic [TAP_W-1:0]  to_state;
        logic [TICK_W-1:0] tick_delta;
        logic [TIME_W-1:0] time_delta;
        logic [WORD_W-1:0] in_low;
        logic [WORD_W-1:0] in_high;
        logic [WORD_W-1:0] out_low;
        logic [WORD_W-1:0] out_high;
        logic              bypass_active;
    } record_t;

    // Legal successor lookup.
    function automatic logic tap_legal(input logic [TAP_W-1:0] from_st,
                                       input logic [TAP_W-1:0] to_st);
        logic [15:0] row;
        row = NEXT_OK[from_st];
        return row[to_st];
    endfunction

endpackage

[design/jttc_trace_if.sv]
// ----------------------------------------------------------------------------
// Trace word channel
// Valid/ready channel that carries one captured trace word per transaction.
// ----------------------------------------------------------------------------
interface jttc_trace_if;

    logic                           valid;
    logic                           ready;
    logic [jttc_pkg::WORD_W-1:0]    trace_word;

    modport source (output valid, output trace_word, input ready);
    modport sink   (input valid, input trace_word, output ready);

endinterface

[design/jttc_record_if.sv]
// ----------------------------------------------------------------------------
// Checker record channel
// Valid/ready channel that carries one checker record per transaction.
// ----------------------------------------------------------------------------
interface jttc_record_if;

    logic                           valid;
    logic                           ready;
    logic [jttc_pkg::KIND_W-1:0]    record_kind;
    logic [jttc_pkg::FROM_W-1:0]    from_state;
    logic [jttc_pkg::TAP_W-1:0]     to_state;
    logic [jttc_pkg::TICK_W-1:0]    tick_delta;
    logic [jttc_pkg::TIME_W-1:0]    time_delta;
    logic [jttc_pkg::WORD_W-1:0]    in_low;
    logic [jttc_pkg::WORD_W-1:0]    in_high;
    logic [jttc_pkg::WORD_W-1:0]    out_low;
    logic [jttc_pkg::WORD_W-1:0]    out_high;
    logic                           bypass_active;

    modport source (
        output valid, output record_kind, output from_state, output to_state,
        output tick_delta, output time_delta, output in_low, output in_high,
        output out_low, output out_high, output bypass_active, input ready
    );
    modport sink (
        input valid, input record_kind, input from_state, input to_state,
        input tick_delta, input time_delta, input in_low, input in_high,
        input out_low, input out_high, input bypass_active, output ready
    );

endinterface

[design/jtag_tap_trace_checker.sv]
// ----------------------------------------------------------------------------
// JTAG TAP trace checker
// Checks a timestamp/state trace word stream and emits TAP activity records.
// ----------------------------------------------------------------------------
// The checker takes one trace word per clock cycle and emits at most one
// record per word. Each word is decoded and the checker state updated in the
// same cycle it is accepted; a resulting record is queued for the record
// channel behind earlier ones. Records queue in a two-entry output buffer, so
// the trace input keeps accepting words while one record waits; it stalls
// only when both buffer entries are occupied. An illegal TAP transition is
// reported once, after which all trace words are consumed silently until
// rst_n is asserted. The IR chain length register lives at byte address 0
// of the APB port and should be written only while the checker is idle.
// ----------------------------------------------------------------------------
`include "jtag_tap_trace_checker_defines.svh"

module jtag_tap_trace_checker (
    input  logic                                clk,
    input  logic                                rst_n,
    jttc_trace_if.sink                          trace,
    jttc_record_if.source                       report,
    input  logic                                psel,
    input  logic                                penable,
    input  logic                                pwrite,
    input  logic [jttc_pkg::PADDR_W-1:0]        paddr,
    input  logic [jttc_pkg::PDATA_W-1:0]        pwdata,
    output logic [jttc_pkg::PDATA_W-1:0]        prdata,
    output logic                                pready
);

    // Word phase codes.
    localparam logic [2:0] PH_TS     = 3'd0;
    localparam logic [2:0] PH_STATE  = 3'd1;
    localparam logic [2:0] PH_IN_LO  = 3'd2;
    localparam logic [2:0] PH_IN_HI  = 3'd3;
    localparam logic [2:0] PH_OUT_LO = 3'd4;
    localparam logic [2:0] PH_OUT_HI = 3'd5;

    // Checker state.
    logic [2:0]                         phase_reg, phase_next;
    logic [jttc_pkg::FROM_W-1:0]        prev_tap_reg, prev_tap_next;
    logic [jttc_pkg::TAP_W-1:0]         cur_tap_reg, cur_tap_next;
    logic [jttc_pkg::TIME_W-1:0]        held_ts_reg, held_ts_next;
    logic [jttc_pkg::TICK_W-1:0]        last_tick_reg, last_tick_next;
    logic [jttc_pkg::TICK_W-1:0]        held_tick_reg, held_tick_next;
    logic [jttc_pkg::TIME_W-1:0]        idle_mark_reg, idle_mark_next;
    logic [jttc_pkg::WORD_W-1:0]        shift_in_lo_reg, shift_in_lo_next;
    logic [jttc_pkg::WORD_W-1:0]        shift_in_hi_reg, shift_in_hi_next;
    logic [jttc_pkg::WORD_W-1:0]        shift_out_lo_reg, shift_out_lo_next;
    logic [jttc_pkg::BYPASS_W-1:0]      bypass_reg, bypass_next;
    logic                               halted_reg, halted_next;
    logic [jttc_pkg::IR_LEN_W-1:0]      ir_len_reg;

    // Output buffer.
    logic                               out_valid_reg;
    logic                               skid_valid_reg;
    jttc_pkg::record_t                  out_data_reg;
    jttc_pkg::record_t                  skid_data_reg;

    // Decode signals.
    logic                               in_fire;
    logic                               out_fire;
    logic                               push;
    logic                               res_valid;
    jttc_pkg::record_t                  res;
    logic [jttc_pkg::WORD_W-1:0]        w;
    logic                               is_ts;
    logic [jttc_pkg::TAP_W-1:0]         code;
    logic [jttc_pkg::TICK_W-1:0]        tick_d;
    logic                               ir_len_hit;
    logic                               cfg_write;

    assign in_fire  = trace.valid && trace.ready;
    assign out_fire = report.valid && report.ready;
    assign w        = trace.trace_word;
    assign is_ts    = w[31];
    assign code     = w[30:27];
    assign tick_d   = w[jttc_pkg::TICK_W-1:0] - last_tick_reg;
    assign ir_len_hit = (held_tick_reg ==
        {{(jttc_pkg::TICK_W-jttc_pkg::IR_LEN_W){1'b0}}, ir_len_reg});

    // Configuration port.
    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready
                       && (paddr[2] == jttc_pkg::REG_IR_CHAIN_LENGTH);
    assign prdata    = (paddr[2] == jttc_pkg::REG_IR_CHAIN_LENGTH)
        ? {{(jttc_pkg::PDATA_W-jttc_pkg::IR_LEN_W){1'b0}}, ir_len_reg}
        : '0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ir_len_reg <= jttc_pkg::IR_LEN_RESET;
        end
        else if (cfg_write)
        begin
            ir_len_reg <= pwdata[jttc_pkg::IR_LEN_W-1:0];
        end
    end

    // Word decode and next-state logic for one accepted trace word.
    always_comb
    begin
        phase_next        = phase_reg;
        prev_tap_next     = prev_tap_reg;
        cur_tap_next      = cur_tap_reg;
        held_ts_next      = held_ts_reg;
        last_tick_next    = last_tick_reg;
        held_tick_next    = held_tick_reg;
        idle_mark_next    = idle_mark_reg;
        shift_in_lo_next  = shift_in_lo_reg;
        shift_in_hi_next  = shift_in_hi_reg;
        shift_out_lo_next = shift_out_lo_reg;
        bypass_next       = bypass_reg;
        halted_next       = halted_reg;
        res_valid         = 1'b0;
        res               = '0;
        res.from_state    = prev_tap_reg;
        res.to_state      = code;

        if (in_fire && !halted_reg)
        begin
            case (phase_reg)
                PH_STATE:
                begin
                    phase_next = PH_TS;
                    if (is_ts)
                    begin
                        res_valid       = 1'b1;
                        res.record_kind = jttc_pkg::KIND_SEQ_ERR;
                    end
                    else
                    begin
                        prev_tap_next = {1'b0, code};
                        cur_tap_next  = code;
                        if (!prev_tap_reg[jttc_pkg::FROM_W-1]
                            && !jttc_pkg::tap_legal(
                                prev_tap_reg[jttc_pkg::TAP_W-1:0], code))
                        begin
                            halted_next     = 1'b1;
                            res_valid       = 1'b1;
                            res.record_kind = jttc_pkg::KIND_ILLEGAL;
                        end
                        else
                        begin
                            held_tick_next = tick_d;
                            last_tick_next = w[jttc_pkg::TICK_W-1:0];
                            res.tick_delta = tick_d;
                            if ((code == jttc_pkg::ST_DR_PAUSE)
                                || (code == jttc_pkg::ST_IR_PAUSE))
                            begin
                                res_valid       = 1'b1;
                                res.record_kind = jttc_pkg::KIND_PAUSE;
                            end
                            else if (code == jttc_pkg::ST_RESET)
                            begin
                                idle_mark_next  = held_ts_reg;
                                res_valid       = 1'b1;
                                res.record_kind = jttc_pkg::KIND_RESET;
                            end
                            else if (code == jttc_pkg::ST_IDLE)
                            begin
                                idle_mark_next  = held_ts_reg;
                                res_valid       = 1'b1;
                                res.record_kind = jttc_pkg::KIND_IDLE;
                                res.time_delta  = held_ts_reg - idle_mark_reg;
                            end
                            else if ((code == jttc_pkg::ST_DR_EXIT1)
                                     || (code == jttc_pkg::ST_IR_EXIT1))
                            begin
                                phase_next = PH_IN_LO;
                            end
                        end
                    end
                end
                PH_IN_LO:
                begin
                    shift_in_lo_next = w;
                    phase_next       = PH_IN_HI;
                end
                PH_IN_HI:
                begin
                    shift_in_hi_next = w;
                    phase_next       = PH_OUT_LO;
                end
                PH_OUT_LO:
                begin
                    shift_out_lo_next = w;
                    phase_next        = PH_OUT_HI;
                end
                PH_OUT_HI:
                begin
                    // Fourth data word closes an IR or DR record.
                    phase_next      = PH_TS;
                    res_valid       = 1'b1;
                    res.from_state  = {1'b0, cur_tap_reg};
                    res.to_state    = cur_tap_reg;
                    res.tick_delta  = held_tick_reg;
                    res.in_low      = shift_in_lo_reg;
                    res.in_high     = shift_in_hi_reg;
                    res.out_low     = shift_out_lo_reg;
                    res.out_high    = w;
                    if ((cur_tap_reg == jttc_pkg::ST_IR_EXIT1) && ir_len_hit)
                    begin
                        bypass_next     = shift_in_lo_reg[jttc_pkg::BYPASS_W-1:0];
                        res.record_kind = jttc_pkg::KIND_IR_MATCHED;
                    end
                    else if (cur_tap_reg == jttc_pkg::ST_DR_EXIT1)
                    begin
                        res.record_kind = jttc_pkg::KIND_DR;
                        if (bypass_reg == jttc_pkg::BYPASS_ALL)
                        begin
                            // Drop the bypass bit from each 64-bit word.
                            res.in_low   = {shift_in_hi_reg[0], shift_in_lo_reg[31:1]};
                            res.in_high  = {1'b0, shift_in_hi_reg[31:1]};
                            res.out_low  = {w[0], shift_out_lo_reg[31:1]};
                            res.out_high = {1'b0, w[31:1]};
                        end
                    end
                    else
                    begin
                        res.record_kind = jttc_pkg::KIND_IR_OTHER;
                    end
                end
                default:
                begin
                    // Expecting a timestamp word.
                    phase_next = PH_TS;
                    if (!is_ts)
                    begin
                        res_valid       = 1'b1;
                        res.record_kind = jttc_pkg::KIND_SEQ_ERR;
                    end
                    else
                    begin
                        held_ts_next = w[jttc_pkg::TIME_W-1:0];
                        phase_next   = PH_STATE;
                    end
                end
            endcase
        end
        res.bypass_active = (bypass_next == jttc_pkg::BYPASS_ALL);
    end

    // Checker state registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg        <= PH_TS;
            prev_tap_reg     <= jttc_pkg::ST_NONE;
            cur_tap_reg      <= jttc_pkg::ST_RESET;
            held_ts_reg      <= '0;
            last_tick_reg    <= '0;
            held_tick_reg    <= '0;
            idle_mark_reg    <= '0;
            shift_in_lo_reg  <= '0;
            shift_in_hi_reg  <= '0;
            shift_out_lo_reg <= '0;
            bypass_reg       <= '0;
            halted_reg       <= 1'b0;
        end
        else
        begin
            phase_reg        <= phase_next;
            prev_tap_reg     <= prev_tap_next;
            cur_tap_reg      <= cur_tap_next;
            held_ts_reg      <= held_ts_next;
            last_tick_reg    <= last_tick_next;
            held_tick_reg    <= held_tick_next;
            idle_mark_reg    <= idle_mark_next;
            shift_in_lo_reg  <= shift_in_lo_next;
            shift_in_hi_reg  <= shift_in_hi_next;
            shift_out_lo_reg <= shift_out_lo_next;
            bypass_reg       <= bypass_next;
            halted_reg       <= halted_next;
        end
    end

    // Two-entry record buffer; the input stalls only when both are full.
    assign trace.ready = !skid_valid_reg;
    assign push        = in_fire && res_valid;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else if (skid_valid_reg)
        begin
            if (out_fire)
            begin
                skid_valid_reg <= 1'b0;
            end
        end
        else if (!out_valid_reg || out_fire)
        begin
            out_valid_reg <= push;
        end
        else if (push)
        begin
            skid_valid_reg <= 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (skid_valid_reg)
        begin
            if (out_fire)
            begin
                out_data_reg <= skid_data_reg;
            end
        end
        else if (!out_valid_reg || out_fire)
        begin
            if (push)
            begin
                out_data_reg <= res;
            end
        end
        else if (push)
        begin
            skid_data_reg <= res;
        end
    end

    // Record channel outputs.
    assign report.valid         = out_valid_reg;
    assign report.record_kind   = out_data_reg.record_kind;
    assign report.from_state    = out_data_reg.from_state;
    assign report.to_state      = out_data_reg.to_state;
    assign report.tick_delta    = out_data_reg.tick_delta;
    assign report.time_delta    = out_data_reg.time_delta;
    assign report.in_low        = out_data_reg.in_low;
    assign report.in_high       = out_data_reg.in_high;
    assign report.out_low       = out_data_reg.out_low;
    assign report.out_high      = out_data_reg.out_high;
    assign report.bypass_active = out_data_reg.bypass_active;

    // Assertions.
    `JTTC_ASSERT_NEXT(a_halt_sticky, clk, rst_n, halted_reg, halted_reg)
    `JTTC_ASSERT_IMPLIES(a_halt_silent, clk, rst_n, halted_reg, !push)
    `JTTC_ASSERT_IMPLIES(a_skid_behind_out, clk, rst_n, skid_valid_reg, out_valid_reg)
    `JTTC_ASSERT_IMPLIES(a_data_after_exit1, clk, rst_n,
        (phase_reg == PH_OUT_HI) || (phase_reg == PH_IN_LO),
        (cur_tap_reg == jttc_pkg::ST_DR_EXIT1) || (cur_tap_reg == jttc_pkg::ST_IR_EXIT1))

endmodule
